// ===== sv/spfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfb_pkg
// Shared types and constants for the spline point evaluator.
// ----------------------------------------------------------------------------
package spfb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_READ,
    ST_DRAIN,
    ST_MSTART,
    ST_MERGE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_EVAL,
    MS_SETUP,
    MS_DIV,
    MS_DONE
  } mstate_t;

  localparam logic [1:0] STATUS_OK            = 2'd0;
  localparam logic [1:0] STATUS_BAD_INTERVAL  = 2'd1;
  localparam logic [1:0] STATUS_ZERO_WEIGHT   = 2'd2;

  localparam logic [1:0] CFG_ORDER    = 2'd0;
  localparam logic [1:0] CFG_DIM      = 2'd1;
  localparam logic [1:0] CFG_RATIONAL = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam int COEF_W     = 32;
  localparam int BASIS_W    = 16;
  localparam int BASIS_FRAC = 15;
  localparam int NUM_BASIS  = 4;
  localparam int NUM_COORD  = 3;
  localparam int QUO_BITS   = 33;
  localparam int PROD_W     = COEF_W + BASIS_W + 1;

  typedef struct packed {
    logic rd_en;
    logic acc_clr;
  } lane_ctl_t;

  typedef struct packed {
    logic       start;
    logic       bad;
    logic       rational;
    logic [2:0] dim;
  } merge_ctl_t;

endpackage

// ===== sv/spfb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/spfb_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfb_lane
// One coordinate slot: coefficient RAM, basis multiplier and accumulator.
// ----------------------------------------------------------------------------
module spfb_lane #(
  parameter int DEPTH = 256,
  parameter int ACC_W = 52
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [spfb_pkg::COEF_W-1:0]       wr_data,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  input  logic [spfb_pkg::BASIS_W-1:0]      basis,
  input  spfb_pkg::lane_ctl_t               ctl,
  output logic signed [ACC_W-1:0]           acc_o
);

  logic [spfb_pkg::COEF_W-1:0]          rd_data;
  logic                                 v1_r;
  logic                                 v2_r;
  logic [spfb_pkg::BASIS_W-1:0]         b1_r;
  logic signed [spfb_pkg::PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]              acc_r;

  spfb_ram #(
    .WIDTH (spfb_pkg::COEF_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.rd_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    b1_r <= basis;
    if (v1_r) begin
      prod_r <= $signed(rd_data) * $signed({1'b0, b1_r});
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + {{(ACC_W-spfb_pkg::PROD_W){prod_r[spfb_pkg::PROD_W-1]}}, prod_r};
    end
  end

  assign acc_o = acc_r;

endmodule

// ===== sv/spfb_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfb_merge
// Rounds lane sums, saturates, and divides by the weight sum one quotient
// bit per cycle in rational mode.
// ----------------------------------------------------------------------------
module spfb_merge #(
  parameter int LANES     = 4,
  parameter int ACC_W     = 52,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  spfb_pkg::merge_ctl_t                   ctl,
  input  logic [LANES-1:0][ACC_W-1:0]            acc_i,
  output logic                                   done,
  output logic [spfb_pkg::NUM_COORD-1:0][31:0]   coord,
  output logic [1:0]                             status
);

  localparam int RW = ACC_W - spfb_pkg::BASIS_FRAC + 1;
  localparam int NW = RW + 34;
  localparam int LW = $clog2(LANES);

  spfb_pkg::mstate_t mst_r, mst_nxt;

  logic [LANES-1:0][RW-1:0]                 rnd_w;
  logic [LANES-1:0][RW-1:0]                 rnd_r;
  logic signed [RW-1:0]                     w_r;
  logic [2:0]                               dim_r;
  logic                                     rat_r;
  logic                                     bad_r;
  logic [1:0]                               c_r;
  logic [NW-1:0]                            rem_r;
  logic [NW-1:0]                            ds_r;
  logic [spfb_pkg::QUO_BITS-1:0]            q_r;
  logic [5:0]                               cnt_r;
  logic                                     ovf_r;
  logic                                     neg_r;
  logic [spfb_pkg::NUM_COORD-1:0][31:0]     res_r;
  logic [1:0]                               status_r;

  logic signed [RW-1:0]                     num_s;
  logic [RW-1:0]                            n_mag;
  logic [RW-1:0]                            d_mag;
  logic [NW-1:0]                            n_ext;
  logic [NW-1:0]                            d2_ext;
  logic                                     ge;
  logic [spfb_pkg::QUO_BITS-1:0]            q_fin;
  logic                                     big;
  logic [31:0]                              div_res;
  logic                                     last_coord;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      logic [ACC_W:0] sum;
      sum = {acc_i[j][ACC_W-1], acc_i[j]} + (ACC_W+1)'(1 << (spfb_pkg::BASIS_FRAC-1));
      rnd_w[j] = sum[ACC_W:spfb_pkg::BASIS_FRAC];
    end
  end

  function automatic logic [31:0] sat32(input logic [RW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[RW-1:31];
    hi_zeros = ~|v[RW-1:31];
    if (hi_ones || hi_zeros) begin
      sat32 = v[31:0];
    end else if (v[RW-1]) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = 32'h7FFF_FFFF;
    end
  endfunction

  // divider setup and step
  always_comb begin
    num_s  = $signed(rnd_r[c_r[LW-1:0]]);
    n_mag  = num_s[RW-1] ? RW'(-num_s) : RW'(num_s);
    d_mag  = w_r[RW-1] ? RW'(-w_r) : RW'(w_r);
    n_ext  = (NW'(n_mag) << (FRAC_BITS + 1)) + NW'(d_mag);
    d2_ext = NW'(d_mag) << 1;
    ge     = rem_r >= ds_r;
    q_fin  = {q_r[spfb_pkg::QUO_BITS-2:0], ge};
    big    = ovf_r | q_fin[32];
    if (!neg_r) begin
      div_res = (big || q_fin[31]) ? 32'h7FFF_FFFF : q_fin[31:0];
    end else begin
      div_res = (big || (q_fin[31] && (q_fin[30:0] != '0))) ? 32'h8000_0000
                                                           : 32'(-q_fin[31:0]);
    end
    last_coord = (3'(c_r) + 3'd1) >= dim_r;
  end

  always_comb begin
    mst_nxt = mst_r;
    case (mst_r)
      spfb_pkg::MS_IDLE: begin
        if (ctl.start) begin
          mst_nxt = spfb_pkg::MS_EVAL;
        end
      end
      spfb_pkg::MS_EVAL: begin
        if (bad_r || !rat_r || (w_r == '0)) begin
          mst_nxt = spfb_pkg::MS_DONE;
        end else begin
          mst_nxt = spfb_pkg::MS_SETUP;
        end
      end
      spfb_pkg::MS_SETUP: mst_nxt = spfb_pkg::MS_DIV;
      spfb_pkg::MS_DIV: begin
        if (cnt_r == '0) begin
          mst_nxt = last_coord ? spfb_pkg::MS_DONE : spfb_pkg::MS_SETUP;
        end
      end
      spfb_pkg::MS_DONE: mst_nxt = spfb_pkg::MS_IDLE;
      default:           mst_nxt = spfb_pkg::MS_IDLE;
    endcase
  end

  always_comb begin
    done   = (mst_r == spfb_pkg::MS_DONE);
    coord  = res_r;
    status = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mst_r <= spfb_pkg::MS_IDLE;
    end else begin
      mst_r <= mst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (mst_r)
      spfb_pkg::MS_IDLE: begin
        if (ctl.start) begin
          rnd_r    <= rnd_w;
          w_r      <= $signed(rnd_w[ctl.dim[LW-1:0]]);
          dim_r    <= ctl.dim;
          rat_r    <= ctl.rational;
          bad_r    <= ctl.bad;
          c_r      <= '0;
          res_r    <= '0;
          status_r <= spfb_pkg::STATUS_OK;
        end
      end
      spfb_pkg::MS_EVAL: begin
        if (bad_r) begin
          status_r <= spfb_pkg::STATUS_BAD_INTERVAL;
        end else if (!rat_r) begin
          for (int j = 0; j < spfb_pkg::NUM_COORD; j++) begin
            if ((j < LANES) && (3'(j) < dim_r)) begin
              res_r[j] <= sat32(rnd_r[j % LANES]);
            end
          end
        end else if (w_r == '0) begin
          status_r <= spfb_pkg::STATUS_ZERO_WEIGHT;
        end
      end
      spfb_pkg::MS_SETUP: begin
        rem_r <= n_ext;
        ds_r  <= d2_ext << 32;
        ovf_r <= n_ext >= (d2_ext << 33);
        neg_r <= num_s[RW-1] ^ w_r[RW-1];
        q_r   <= '0;
        cnt_r <= 6'(spfb_pkg::QUO_BITS - 1);
      end
      spfb_pkg::MS_DIV: begin
        if (ge) begin
          rem_r <= rem_r - ds_r;
        end
        ds_r  <= ds_r >> 1;
        q_r   <= q_fin;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          res_r[c_r] <= div_res;
          c_r        <= c_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/spline_point_from_basis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_point_from_basis
// B-spline curve point evaluation from precomputed basis values, with a
// per-slot coefficient store and optional rational (weighted) division.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Contents
// in       in   in_tvalid/tready   load word or evaluate request
// out      out  out_tvalid/tready  curve point and status
// cfg      in   cfg_wr_en          order, dimension, rational mode
//
// A load word is written straight into the store. An evaluate word reads k
// store rows (k = order), one row a cycle, then the merge rounds the sums and,
// in rational mode, divides each coordinate with a bit-serial divider; the
// start point is first brought below NUM_POINTS. One word is worked at a time;
// loads proceed while a result waits in the output register. Reset is
// synchronous; the store is not cleared.
// ----------------------------------------------------------------------------
module spline_point_from_basis #(
  parameter int MAX_ORDER       = 4,
  parameter int NUM_POINTS      = 256,
  parameter int SLOTS_PER_POINT = 4,
  parameter int FRAC_BITS       = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // coef_index[9:0], coef_value[41:10], interval_index[49:42],
  // basis_0[65:50], basis_1[81:66], basis_2[97:82], basis_3[113:98]
  input  logic [119:0]  in_tdata,
  input  logic          in_tuser,   // op
  input  logic          in_tlast,   // last_point
  output logic          out_tvalid,
  input  logic          out_tready,
  // coord_x[31:0], coord_y[63:32], coord_z[95:64], status[97:96]
  output logic [103:0]  out_tdata,
  output logic          out_tlast,  // end_of_polyline
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_addr,
  input  logic [2:0]    cfg_wr_data
);

  localparam int PAW         = $clog2(NUM_POINTS);
  localparam int PW          = (PAW + 1 > 9) ? PAW + 1 : 9;
  localparam int KW          = ($clog2(MAX_ORDER + 1) < 2) ? 2 : $clog2(MAX_ORDER + 1);
  localparam int ACC_W       = spfb_pkg::PROD_W + $clog2(MAX_ORDER) + 1;
  localparam int STORE_DEPTH = NUM_POINTS * SLOTS_PER_POINT;
  localparam int RECIP       = (65536 + SLOTS_PER_POINT - 1) / SLOTS_PER_POINT;

  spfb_pkg::state_t state_r, state_nxt;

  logic [2:0]   order_r;
  logic [1:0]   dim_cfg_r;
  logic         rat_cfg_r;

  logic [KW-1:0]  k_r;
  logic [2:0]     dim_r;
  logic           rat_r;
  logic           bad_r;
  logic           last_r;
  logic [PW-1:0]  p_r;
  logic [KW-1:0]  i_r;
  logic [1:0]     drain_r;
  logic [spfb_pkg::NUM_BASIS-1:0][spfb_pkg::BASIS_W-1:0] basis_r;

  logic                      out_valid_r;
  logic [103:0]              out_data_r;
  logic                      out_last_r;

  logic        acc_in;
  logic        is_load;
  logic        is_eval;
  logic [9:0]  ld_addr;
  logic [31:0] ld_prod;
  logic [PAW-1:0] ld_point;
  logic [2:0]  ld_slot;
  logic        ld_ok;
  logic [7:0]  left_w;
  logic [KW-1:0] k_w;
  logic [2:0]  dim_w;
  logic        bad_w;

  spfb_pkg::lane_ctl_t  lane_ctl;
  spfb_pkg::merge_ctl_t merge_ctl;
  logic [spfb_pkg::BASIS_W-1:0] basis_sel;
  logic [SLOTS_PER_POINT-1:0][ACC_W-1:0] acc_w;
  logic                                   m_done;
  logic [spfb_pkg::NUM_COORD-1:0][31:0]   m_coord;
  logic [1:0]                             m_status;

  assign in_tready = (state_r == spfb_pkg::ST_IDLE);
  assign acc_in    = in_tvalid && in_tready;
  assign is_load   = acc_in && (in_tuser == spfb_pkg::OP_LOAD);
  assign is_eval   = acc_in && (in_tuser == spfb_pkg::OP_EVAL);

  // load address split into point and slot
  always_comb begin
    ld_addr  = in_tdata[9:0];
    ld_prod  = 32'(ld_addr) * 32'(RECIP);
    ld_point = PAW'(ld_prod >> 16);
    ld_slot  = 3'(32'(ld_addr) - 32'(ld_point) * 32'(SLOTS_PER_POINT));
    ld_ok    = 32'(ld_addr) < 32'(STORE_DEPTH);
  end

  // order and dimension clamp, interval check
  always_comb begin
    left_w = in_tdata[49:42];
    if (order_r == '0) begin
      k_w = KW'(1);
    end else if (32'(order_r) > 32'(MAX_ORDER)) begin
      k_w = KW'(MAX_ORDER);
    end else begin
      k_w = KW'(order_r);
    end
    dim_w = (dim_cfg_r == '0) ? 3'd1 : 3'(dim_cfg_r);
    if (rat_cfg_r) begin
      if (32'(dim_w) > 32'(SLOTS_PER_POINT - 1)) dim_w = 3'(SLOTS_PER_POINT - 1);
    end else if (32'(dim_w) > 32'(SLOTS_PER_POINT)) begin
      dim_w = 3'(SLOTS_PER_POINT);
    end
    bad_w = (9'(left_w) + 9'd1) < 9'(k_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r   <= 3'd4;
      dim_cfg_r <= 2'd3;
      rat_cfg_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        spfb_pkg::CFG_ORDER:    order_r   <= cfg_wr_data;
        spfb_pkg::CFG_DIM:      dim_cfg_r <= cfg_wr_data[1:0];
        spfb_pkg::CFG_RATIONAL: rat_cfg_r <= cfg_wr_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spfb_pkg::ST_IDLE: begin
        if (is_eval) begin
          state_nxt = bad_w ? spfb_pkg::ST_MSTART : spfb_pkg::ST_WRAP;
        end
      end
      spfb_pkg::ST_WRAP: begin
        if (32'(p_r) < 32'(NUM_POINTS)) state_nxt = spfb_pkg::ST_READ;
      end
      spfb_pkg::ST_READ: begin
        if (i_r == k_r - KW'(1)) state_nxt = spfb_pkg::ST_DRAIN;
      end
      spfb_pkg::ST_DRAIN: begin
        if (drain_r == 2'd1) state_nxt = spfb_pkg::ST_MSTART;
      end
      spfb_pkg::ST_MSTART: state_nxt = spfb_pkg::ST_MERGE;
      spfb_pkg::ST_MERGE: begin
        if (m_done) state_nxt = spfb_pkg::ST_DONE;
      end
      spfb_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = spfb_pkg::ST_IDLE;
      end
      default: state_nxt = spfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    lane_ctl.rd_en     = (state_r == spfb_pkg::ST_READ);
    lane_ctl.acc_clr   = is_eval;
    merge_ctl.start    = (state_r == spfb_pkg::ST_MSTART);
    merge_ctl.bad      = bad_r;
    merge_ctl.rational = rat_r;
    merge_ctl.dim      = dim_r;
    basis_sel = (32'(i_r) < spfb_pkg::NUM_BASIS) ? basis_r[i_r[1:0]] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spfb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      spfb_pkg::ST_IDLE: begin
        if (is_eval) begin
          k_r     <= k_w;
          dim_r   <= dim_w;
          rat_r   <= rat_cfg_r;
          bad_r   <= bad_w;
          last_r  <= in_tlast;
          p_r     <= PW'(9'(left_w) + 9'd1 - 9'(k_w));
          i_r     <= '0;
          drain_r <= '0;
          basis_r <= {in_tdata[113:98], in_tdata[97:82], in_tdata[81:66], in_tdata[65:50]};
        end
      end
      spfb_pkg::ST_WRAP: begin
        if (32'(p_r) >= 32'(NUM_POINTS)) p_r <= p_r - PW'(NUM_POINTS);
      end
      spfb_pkg::ST_READ: begin
        p_r <= (32'(p_r) + 1 == 32'(NUM_POINTS)) ? '0 : p_r + PW'(1);
        i_r <= i_r + KW'(1);
      end
      spfb_pkg::ST_DRAIN: drain_r <= drain_r + 2'd1;
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < SLOTS_PER_POINT; g++) begin : g_lane
    spfb_lane #(
      .DEPTH (NUM_POINTS),
      .ACC_W (ACC_W)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (is_load && ld_ok && (ld_slot == 3'(g))),
      .wr_addr (ld_point),
      .wr_data (in_tdata[41:10]),
      .rd_addr (p_r[PAW-1:0]),
      .basis   (basis_sel),
      .ctl     (lane_ctl),
      .acc_o   (acc_w[g])
    );
  end

  spfb_merge #(
    .LANES     (SLOTS_PER_POINT),
    .ACC_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (merge_ctl),
    .acc_i  (acc_w),
    .done   (m_done),
    .coord  (m_coord),
    .status (m_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == spfb_pkg::ST_DONE) && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == spfb_pkg::ST_DONE) && (!out_valid_r || out_tready)) begin
      out_data_r <= {6'd0, m_status, m_coord[2], m_coord[1], m_coord[0]};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
